// ----- hw/rtl/sha256_pkg.sv -----
// SHA-256 stream hasher package: round constants, initial vector, sequencer states.
// Depends on nothing; used by sha256_stream_hasher_top and sha256_round.
`default_nettype none
package sha256_pkg;
    localparam int unsigned WordW = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef logic [31:0] t_word;

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
                6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
                6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
                6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
                6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
                6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
                6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
                6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
                6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
                6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
                6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
                6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic t_word init_vec(input logic [2:0] idx);
        t_word v;
        begin
            unique case (idx)
                3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab; 3'd7: v = 32'h5be0cd19;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    function automatic t_word ror(input t_word v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/sha256_if.sv -----
// Valid/ready stream interfaces for the hasher's request and digest channels.
// Depends on nothing.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// SHA-256 stream hasher top: byte packing, padding, block compression, digest output.
// Depends on sha256_pkg, sha256_if, sha256_ram, sha256_round.
//
// Each byte taken is packed into the block register; the 64th byte of a block starts the
// rounds on the single round unit and then the fold; no request is taken meanwhile.
// An end marker adds padding and length bytes (a second block when the residue passes 55
// bytes), then the eight digest words, one digest word per cycle unstalled.
// Reset and each digest load the initial vector into the chaining RAM and working
// registers through a sweep of the eight RAM words; no request is taken during it.
`default_nettype none
module sha256_stream_hasher_top (
    input  wire i_clk,
    input  wire i_rst_n,
    sha256_in_if.sink    i_req,
    sha256_out_if.source o_dig
);
    sha256_pkg::t_state r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_total, n_total;
    logic        r_final, n_final;
    logic        r_mark, n_mark;
    logic        r_lendone, n_lendone;
    logic        r_init, n_init;
    logic [6:0]  r_cnt, n_cnt;
    sha256_pkg::t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    sha256_pkg::t_word r_w [16];
    sha256_pkg::t_word r_blk [16];
    logic        r_ovalid, n_ovalid;
    sha256_pkg::t_word r_oword;
    logic [2:0]  r_oidx;

    logic        ch_we;
    logic [2:0]  ch_waddr, ch_raddr;
    sha256_pkg::t_word ch_wdata, ch_rdata;
    sha256_pkg::t_word rnd_a, rnd_e, rnd_w;
    logic        byte_we;
    logic [7:0]  byte_val;
    logic        take;
    logic        blk_full;

    sha256_ram #(.Width(32), .Depth(8)) u_chain (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata)
    );

    sha256_round u_round (
        .i_a(r_a), .i_b(r_b), .i_c(r_c), .i_d(r_d),
        .i_e(r_e), .i_f(r_f), .i_g(r_g), .i_h(r_h),
        .i_k(sha256_pkg::round_const(r_cnt[5:0])), .i_w(r_w[0]),
        .i_w2(r_w[14]), .i_w7(r_w[9]), .i_w15(r_w[1]), .i_w16(r_w[0]),
        .o_a(rnd_a), .o_e(rnd_e), .o_wnext(rnd_w)
    );

    assign take = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == sha256_pkg::ST_LOAD) && !r_init;
    assign o_dig.valid = r_ovalid;
    assign o_dig.digest_word = r_oword;
    assign o_dig.word_index = r_oidx;
    assign o_dig.last_word = (r_oidx == 3'd7);
    assign blk_full = (r_fill == 6'd63);

    always_comb begin
        byte_we  = 1'b0;
        byte_val = 8'h00;
        unique case (r_state)
            sha256_pkg::ST_LOAD: begin
                byte_we  = take && i_req.byte_present;
                byte_val = i_req.msg_byte;
            end
            sha256_pkg::ST_PAD: begin
                byte_we  = 1'b1;
                byte_val = r_mark ? 8'h00 : 8'h80;
            end
            sha256_pkg::ST_LEN: begin
                byte_we  = 1'b1;
                byte_val = r_total[63:56];
            end
            default: ;
        endcase
    end

    always_comb begin
        ch_we    = 1'b0;
        ch_waddr = r_cnt[2:0];
        ch_wdata = sha256_pkg::init_vec(r_cnt[2:0]);
        ch_raddr = 3'd0;
        unique case (r_state)
            sha256_pkg::ST_LOAD: begin
                ch_we    = r_init;
                ch_raddr = 3'd0;
            end
            sha256_pkg::ST_ROUND: ch_raddr = 3'd0;
            sha256_pkg::ST_FOLD: begin
                ch_we    = 1'b1;
                ch_wdata = ch_rdata + r_a;
                ch_raddr = r_cnt[2:0] + 3'd1;
            end
            sha256_pkg::ST_OUT: begin
                ch_raddr = (!r_ovalid || o_dig.ready) ? r_cnt[2:0] + 3'd1 : r_cnt[2:0];
            end
            default: ch_raddr = 3'd0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_total   = r_total;
        n_final   = r_final;
        n_mark    = r_mark;
        n_lendone = r_lendone;
        n_init    = r_init;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid;
        if (o_dig.ready) n_ovalid = 1'b0;
        if (byte_we) n_fill = r_fill + 6'd1;
        unique case (r_state)
            sha256_pkg::ST_LOAD: begin
                if (r_init) begin
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt == 7'd7) begin
                        n_init = 1'b0;
                        n_cnt  = '0;
                    end
                end else if (take) begin
                    if (i_req.byte_present) n_bits = r_bits + 64'd8;
                    n_total = i_req.byte_present ? r_bits + 64'd8 : r_bits;
                    n_final = 1'b0;
                    n_cnt   = '0;
                    if (i_req.byte_present && blk_full) n_state = sha256_pkg::ST_ROUND;
                    if (i_req.end_of_message) begin
                        n_final = 1'b1;
                        n_mark  = 1'b0;
                        if (!(i_req.byte_present && blk_full)) n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                n_mark = 1'b1;
                if (blk_full) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_cnt   = 7'd0;
                end else if (r_fill == 6'd55) begin
                    n_state = sha256_pkg::ST_LEN;
                    n_cnt   = 7'd0;
                end
            end
            sha256_pkg::ST_LEN: begin
                n_total = {r_total[55:0], 8'h00};
                if (blk_full) begin
                    n_state   = sha256_pkg::ST_ROUND;
                    n_cnt     = 7'd0;
                    n_lendone = 1'b1;
                end
            end
            sha256_pkg::ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = sha256_pkg::ST_FOLD;
                    n_cnt   = 7'd0;
                end
            end
            sha256_pkg::ST_FOLD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd7) begin
                    n_cnt = 7'd0;
                    if (r_lendone) begin
                        n_state = sha256_pkg::ST_OUT;
                    end else if (r_final) begin
                        n_state = sha256_pkg::ST_PAD;
                    end else begin
                        n_state = sha256_pkg::ST_LOAD;
                    end
                end
            end
            sha256_pkg::ST_OUT: begin
                if (!r_ovalid || o_dig.ready) begin
                    n_ovalid = 1'b1;
                    n_cnt    = r_cnt + 7'd1;
                    if (r_cnt == 7'd7) begin
                        n_state   = sha256_pkg::ST_LOAD;
                        n_init    = 1'b1;
                        n_cnt     = '0;
                        n_bits    = '0;
                        n_final   = 1'b0;
                        n_lendone = 1'b0;
                    end
                end
            end
            default: n_state = sha256_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha256_pkg::ST_LOAD;
            r_fill    <= '0;
            r_bits    <= '0;
            r_final   <= 1'b0;
            r_mark    <= 1'b0;
            r_lendone <= 1'b0;
            r_init    <= 1'b1;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_final   <= n_final;
            r_mark    <= n_mark;
            r_lendone <= n_lendone;
            r_init    <= n_init;
            r_cnt     <= n_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        if (byte_we) begin
            case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]][31:24] <= byte_val;
                2'd1: r_blk[r_fill[5:2]][23:16] <= byte_val;
                2'd2: r_blk[r_fill[5:2]][15:8]  <= byte_val;
                default: r_blk[r_fill[5:2]][7:0] <= byte_val;
            endcase
        end
        if (r_state == sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= rnd_w;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= rnd_e;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= rnd_a;
            if (r_cnt == 7'd63) begin
                r_a <= rnd_a; r_b <= r_a; r_c <= r_b; r_d <= r_c;
                r_e <= rnd_e; r_f <= r_e; r_g <= r_f; r_h <= r_g;
            end
        end else if (r_state == sha256_pkg::ST_FOLD ||
                     (r_state == sha256_pkg::ST_LOAD && r_init)) begin
            r_a <= r_b; r_b <= r_c; r_c <= r_d; r_d <= r_e;
            r_e <= r_f; r_f <= r_g; r_g <= r_h; r_h <= ch_wdata;
        end
        if (n_state == sha256_pkg::ST_ROUND && r_state != sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_blk[i];
            if (byte_we) r_w[15] <= {r_blk[15][31:8], byte_val};
        end
        if (r_state == sha256_pkg::ST_OUT && (!r_ovalid || o_dig.ready)) begin
            r_oword <= ch_rdata;
            r_oidx  <= r_cnt[2:0];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sha256_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module sha256_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sha256_round.sv -----
// One SHA-256 round and one message-schedule step on the working registers.
// Depends on sha256_pkg.
`default_nettype none
module sha256_round (
    input  wire sha256_pkg::t_word i_a, i_b, i_c, i_d, i_e, i_f, i_g, i_h,
    input  wire sha256_pkg::t_word i_k,
    input  wire sha256_pkg::t_word i_w,
    input  wire sha256_pkg::t_word i_w2, i_w7, i_w15, i_w16,
    output sha256_pkg::t_word      o_a,
    output sha256_pkg::t_word      o_e,
    output sha256_pkg::t_word      o_wnext
);
    sha256_pkg::t_word big1, choose, sum1, big0, major, lo, hi;

    always_comb begin
        big1   = sha256_pkg::ror(i_e, 6) ^ sha256_pkg::ror(i_e, 11) ^ sha256_pkg::ror(i_e, 25);
        choose = (i_e & i_f) ^ (~i_e & i_g);
        sum1   = i_h + big1 + choose + i_k + i_w;
        big0   = sha256_pkg::ror(i_a, 2) ^ sha256_pkg::ror(i_a, 13) ^ sha256_pkg::ror(i_a, 22);
        major  = (i_a & i_b) ^ (i_a & i_c) ^ (i_b & i_c);
        o_a    = sum1 + big0 + major;
        o_e    = i_d + sum1;
        lo     = sha256_pkg::ror(i_w15, 7) ^ sha256_pkg::ror(i_w15, 18) ^ (i_w15 >> 3);
        hi     = sha256_pkg::ror(i_w2, 17) ^ sha256_pkg::ror(i_w2, 19) ^ (i_w2 >> 10);
        o_wnext = i_w16 + lo + i_w7 + hi;
    end
endmodule
`default_nettype wire

// ----- verif/tb_sha256_stream_hasher_top.sv -----
// Self-checking testbench for the SHA-256 stream hasher: drives byte requests and
// checks every digest word against a hash computed in the bench itself.
// Depends on sha256_if and sha256_stream_hasher_top.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

    typedef struct {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
        logic       wait_drain;
    } byte_req_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha256_in_if  req_if ();
    sha256_out_if dig_if ();

    sha256_stream_hasher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_dig   (dig_if)
    );

    always #5 i_clk = ~i_clk;

    byte_req_t    pending_reqs[$];
    digest_word_t expected_words[$];

    logic [31:0] hash_state [8];
    logic [63:0] msg_bits;
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        long_hold_on = 1'b0;
    int unsigned hold_left = 1500;
    int unsigned err_count = 0;
    int unsigned reqs_taken = 0;
    int unsigned words_seen = 0;
    int unsigned msgs_queued = 0;

    function automatic logic [31:0] rotr(logic [31:0] v, int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int i = 0; i < 8; i++) r[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TAB[t] + w[t];
            t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            for (int i = 7; i > 0; i--) r[i] = r[i-1];
            r[4] = r[4] + t1;
            r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
        msg_bits = '0;
        block_fill = 0;
    endtask

    task automatic hash_request(byte_req_t rq);
        logic [63:0] total;
        digest_word_t dw;
        if (rq.byte_present) begin
            msg_bits += 64'd8;
            absorb_byte(rq.msg_byte);
        end
        if (rq.end_of_message) begin
            total = msg_bits;
            absorb_byte(8'h80);
            while (block_fill != 56) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(total[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                dw.digest_word = hash_state[i];
                dw.word_index = 3'(i);
                dw.last_word = (i == 7);
                expected_words.push_back(dw);
            end
            restart_hash();
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                hash_request(pending_reqs.pop_front());
                reqs_taken++;
            end
            if (req_if.valid && !req_if.ready) begin
                req_if.valid <= 1'b1;
            end else if (pending_reqs.size() > 0
                         && !(pending_reqs[0].wait_drain && expected_words.size() > 0)
                         && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid          <= 1'b1;
                req_if.msg_byte       <= pending_reqs[0].msg_byte;
                req_if.byte_present   <= pending_reqs[0].byte_present;
                req_if.end_of_message <= pending_reqs[0].end_of_message;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        digest_word_t ew;
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("digest word %h with no request pending", dig_if.digest_word);
                    err_count++;
                end else begin
                    ew = expected_words.pop_front();
                    if (dig_if.digest_word !== ew.digest_word) begin
                        $error("digest_word: expected %h, got %h", ew.digest_word,
                               dig_if.digest_word);
                        err_count++;
                    end
                    if (dig_if.word_index !== ew.word_index) begin
                        $error("word_index: expected %0d, got %0d", ew.word_index,
                               dig_if.word_index);
                        err_count++;
                    end
                    if (dig_if.last_word !== ew.last_word) begin
                        $error("last_word: expected %0d, got %0d", ew.last_word,
                               dig_if.last_word);
                        err_count++;
                    end
                end
            end
            if (long_hold_on && hold_left > 0) begin
                dig_if.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                dig_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic byte_req_t mk_req(logic [7:0] b, logic bp, logic eom, logic wd);
        byte_req_t rq;
        rq.msg_byte = b;
        rq.byte_present = bp;
        rq.end_of_message = eom;
        rq.wait_drain = wd;
        return rq;
    endfunction

    task automatic queue_message(int unsigned len, logic wd);
        logic bare;
        bare = (len == 0) || ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0)
                pending_reqs.push_back(mk_req(8'($urandom), 1'b0, 1'b0, 1'b0));
            pending_reqs.push_back(mk_req(8'($urandom), 1'b1, !bare && (i == len - 1),
                                          wd && (i == 0)));
        end
        if (bare) pending_reqs.push_back(mk_req(8'($urandom), 1'b0, 1'b1, wd && (len == 0)));
        msgs_queued++;
    endtask

    task automatic queue_random(int unsigned n_bytes);
        int unsigned total;
        int unsigned len;
        int unsigned pick;
        total = 0;
        while (total < n_bytes) begin
            pick = $urandom_range(9);
            if (pick < 2) len = 55 + $urandom_range(9);
            else if (pick == 2) len = 119 + $urandom_range(2);
            else len = $urandom_range(20);
            queue_message(len, 1'b0);
            total += len + 1;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_words.size() > 0 || req_if.valid)
            @(negedge i_clk);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.msg_byte = '0;
        req_if.byte_present = 1'b0;
        req_if.end_of_message = 1'b0;
        dig_if.ready = 1'b0;
        restart_hash();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, abc, extreme bytes, idle request, byte with marker
        pending_reqs.push_back(mk_req(8'h00, 1'b0, 1'b1, 1'b0));
        pending_reqs.push_back(mk_req(8'h61, 1'b1, 1'b0, 1'b0));
        pending_reqs.push_back(mk_req(8'h62, 1'b1, 1'b0, 1'b0));
        pending_reqs.push_back(mk_req(8'h63, 1'b1, 1'b1, 1'b0));
        pending_reqs.push_back(mk_req(8'hff, 1'b0, 1'b0, 1'b0));
        pending_reqs.push_back(mk_req(8'hff, 1'b1, 1'b1, 1'b0));
        pending_reqs.push_back(mk_req(8'h00, 1'b1, 1'b0, 1'b0));
        pending_reqs.push_back(mk_req(8'h55, 1'b0, 1'b1, 1'b0));
        pending_reqs.push_back(mk_req(8'haa, 1'b1, 1'b1, 1'b0));
        pending_reqs.push_back(mk_req(8'h00, 1'b0, 1'b1, 1'b0));
        msgs_queued += 6;
        wait_drained();

        queue_random(40);
        wait_drained();

        @(negedge i_clk);
        send_idle_pct = 82;
        queue_random(30);
        wait_drained();

        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 82;
        queue_random(30);
        wait_drained();

        @(negedge i_clk);
        send_idle_pct = 25;
        recv_idle_pct = 25;
        queue_random(20);
        queue_message(5, 1'b1);
        queue_random(15);
        wait_drained();

        // receiver holds off while requests keep coming
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_on = 1'b1;
        queue_random(40);
        wait_drained();

        repeat (200) @(posedge i_clk);
        $display("covered %0d messages, %0d requests, %0d digest words under varied stalls",
                 msgs_queued, reqs_taken, words_seen);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
